// File: rtl/pfdc_pkg.sv
package pfdc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int CELL_W      = 5;
    localparam int POS_W       = 3;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] FILLER = 8'h78;

    localparam logic MODE_ENCIPHER = 1'b0;
    localparam logic MODE_DECIPHER = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LAST = 3'd4;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = 3;
    localparam int SLOT_W      = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;

    typedef logic [CELLS-1:0][CHAR_W-1:0] key_square_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_message;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last_in_run;
    } rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0]                   count;
        logic [MAX_RESULTS-1:0][CHAR_W-1:0] chars;
    } push_t;

endpackage

// File: rtl/pfdc_mapper.sv
module pfdc_mapper (
    input  pfdc_pkg::key_square_t key,
    input  logic                  decipher,
    input  logic [7:0]            a_in,
    input  logic [7:0]            b_in,
    output logic [7:0]            a_out,
    output logic [7:0]            b_out
);
    import pfdc_pkg::*;

    logic             found_a, found_b;
    logic [POS_W-1:0] ra, ca, rb, cb;
    logic [POS_W-1:0] nra, nca, nrb, ncb;

    function automatic logic [POS_W-1:0] shift_pos(input logic [POS_W-1:0] x,
                                                   input logic back);
        logic [POS_W-1:0] r;
        if (back)
        begin
            r = (x == '0) ? POS_W'(SQUARE_SIDE - 1) : x - 1'b1;
        end
        else
        begin
            r = (x == POS_W'(SQUARE_SIDE - 1)) ? '0 : x + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_idx(input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
        return CELL_W'(r) * CELL_W'(SQUARE_SIDE) + CELL_W'(c);
    endfunction

    // scan high to low so the lowest-numbered matching cell wins
    always_comb
    begin
        found_a = 1'b0;
        found_b = 1'b0;
        ra = '0;
        ca = '0;
        rb = '0;
        cb = '0;
        for (int r = SQUARE_SIDE - 1; r >= 0; r--)
        begin
            for (int c = SQUARE_SIDE - 1; c >= 0; c--)
            begin
                if (key[r * SQUARE_SIDE + c] == a_in)
                begin
                    found_a = 1'b1;
                    ra = POS_W'(r);
                    ca = POS_W'(c);
                end
                if (key[r * SQUARE_SIDE + c] == b_in)
                begin
                    found_b = 1'b1;
                    rb = POS_W'(r);
                    cb = POS_W'(c);
                end
            end
        end
    end

    always_comb
    begin
        nra = ra;
        nca = ca;
        nrb = rb;
        ncb = cb;
        if (ra == rb)
        begin
            nca = shift_pos(ca, decipher);
            ncb = shift_pos(cb, decipher);
        end
        else if (ca == cb)
        begin
            nra = shift_pos(ra, decipher);
            nrb = shift_pos(rb, decipher);
        end
        else
        begin
            nca = cb;
            ncb = ca;
        end
    end

    // a letter missing from the square leaves the whole pair untouched
    assign a_out = (found_a && found_b) ? key[cell_idx(nra, nca)] : a_in;
    assign b_out = (found_a && found_b) ? key[cell_idx(nrb, ncb)] : b_in;

endmodule

// File: rtl/pfdc_core.sv
module pfdc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  pfdc_pkg::req_t        req,
    input  logic                  mode,
    input  pfdc_pkg::key_square_t key,
    input  logic                  space_ok,
    output pfdc_pkg::push_t       push
);
    import pfdc_pkg::*;

    logic              stg_valid_reg;
    req_t              stg_reg;
    logic              open_reg, open_next;
    logic [CHAR_W-1:0] first_reg, first_next;
    logic              held_valid_reg, held_valid_next;
    logic [CHAR_W-1:0] held_reg, held_next;

    logic              advance;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] map_b, ma, mb;
    logic [CNT_W-1:0]  n;
    logic [MAX_RESULTS-1:0][CHAR_W-1:0] slots;

    assign advance   = stg_valid_reg && space_ok;
    assign req_ready = !stg_valid_reg || space_ok;
    assign c         = stg_reg.char_in;

    // a doubled letter when enciphering pairs with the filler
    assign map_b = (mode == MODE_ENCIPHER && first_reg == c) ? FILLER : c;

    pfdc_mapper u_mapper (
        .key      (key),
        .decipher (mode == MODE_DECIPHER),
        .a_in     (first_reg),
        .b_in     (map_b),
        .a_out    (ma),
        .b_out    (mb)
    );

    always_comb
    begin
        open_next       = open_reg;
        first_next      = first_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        n               = '0;
        slots           = '0;
        if (!open_reg)
        begin
            first_next = c;
            open_next  = 1'b1;
        end
        else if (mode == MODE_ENCIPHER)
        begin
            slots[0] = ma;
            slots[1] = mb;
            n = CNT_W'(2);
            if (first_reg != c)
            begin
                open_next = 1'b0;
            end
        end
        else
        begin
            open_next = 1'b0;
            if (held_valid_reg)
            begin
                slots[n[SLOT_W-1:0]] = held_reg;
                n = n + 1'b1;
                if (ma != held_reg)
                begin
                    slots[n[SLOT_W-1:0]] = FILLER;
                    n = n + 1'b1;
                end
                held_valid_next = 1'b0;
            end
            if (mb == FILLER)
            begin
                held_next       = ma;
                held_valid_next = 1'b1;
            end
            else
            begin
                slots[n[SLOT_W-1:0]] = ma;
                n = n + 1'b1;
                slots[n[SLOT_W-1:0]] = mb;
                n = n + 1'b1;
            end
        end
        // flush a held letter and drop a waiting one
        if (stg_reg.end_of_message)
        begin
            if (held_valid_next)
            begin
                slots[n[SLOT_W-1:0]] = held_next;
                n = n + 1'b1;
                slots[n[SLOT_W-1:0]] = FILLER;
                n = n + 1'b1;
            end
            held_valid_next = 1'b0;
            open_next       = 1'b0;
        end
    end

    assign push.count = advance ? n : '0;
    assign push.chars = slots;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg  <= 1'b0;
            open_reg       <= 1'b0;
            first_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stg_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                open_reg       <= open_next;
                first_reg      <= first_next;
                held_valid_reg <= held_valid_next;
                held_reg       <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            stg_reg <= req;
        end
    end

endmodule

// File: rtl/pfdc_fifo.sv
module pfdc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  pfdc_pkg::push_t push,
    output logic            space_ok,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pfdc_pkg::rsp_t  rsp
);
    import pfdc_pkg::*;

    rsp_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    assign space_ok  = cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS);
    assign rsp_valid = cnt_reg != '0;
    assign rsp       = mem_reg[rd_ptr_reg];
    assign pop       = rsp_valid && rsp_ready;
    assign cnt_next  = cnt_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (CNT_W'(i) < push.count)
            begin
                mem_reg[wr_ptr_reg + FIFO_PTR_W'(i)] <= '{
                    char_out:    push.chars[i],
                    last_in_run: (CNT_W'(i) == push.count - 1'b1)
                };
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push.count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/playfair_digram_cipher.sv
// Playfair digram cipher over a 5x5 key square held in configuration. One
// character request is taken per cycle into a stage register, unless the
// staged request is stalled; from the stage the pair is located and mapped
// in one pass and its zero to four results go into an eight-entry result
// queue, which registers them before offering the first. The queue drains
// one result per cycle while the receiver is ready, and a request waits in
// the stage while the queue holds more than four results; sustained rate is
// therefore one request per cycle as long as results average no more than
// one per request. Write the mode and key registers only while no request
// is in flight.
module playfair_digram_cipher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  pfdc_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output pfdc_pkg::rsp_t                      rsp,
    input  logic                                cfg_we,
    input  logic [pfdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pfdc_pkg::*;

    logic              mode_reg;
    logic [63:0]       key_lo_reg, key_mid_reg, key_hi_reg;
    logic [CHAR_W-1:0] key_last_reg;
    key_square_t       key;
    logic              space_ok;
    push_t             push;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            key[i]      = key_lo_reg[8*i +: 8];
            key[i + 8]  = key_mid_reg[8*i +: 8];
            key[i + 16] = key_hi_reg[8*i +: 8];
        end
        key[CELLS-1] = key_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ENCIPHER;
            key_lo_reg   <= '0;
            key_mid_reg  <= '0;
            key_hi_reg   <= '0;
            key_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[0];
                REG_KEY_LO:   key_lo_reg   <= cfg_data;
                REG_KEY_MID:  key_mid_reg  <= cfg_data;
                REG_KEY_HI:   key_hi_reg   <= cfg_data;
                REG_KEY_LAST: key_last_reg <= cfg_data[CHAR_W-1:0];
                default:      ;
            endcase
        end
    end

    pfdc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .mode      (mode_reg),
        .key       (key),
        .space_ok  (space_ok),
        .push      (push)
    );

    pfdc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import pfdc_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 120;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Expected-output state, mirrors the block after reset
    key_square_t key_sq       = '0;
    logic        cur_mode     = MODE_ENCIPHER;
    bit          pair_open    = 1'b0;
    logic [7:0]  first_letter = '0;
    bit          held_valid   = 1'b0;
    logic [7:0]  held_letter  = '0;
    rsp_t        pending_chars [$];

    rsp_t next_result;
    int   error_count   = 0;
    int   chars_offered = 0;
    int   hold_request  = 0;
    bit   idle_on       = 1'b1;

    playfair_digram_cipher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[playfair_digram_cipher] ERROR");
        $finish;
    end

    function automatic int find_cell(input logic [7:0] c);
        for (int i = 0; i < CELLS; i++)
            if (key_sq[i] == c)
                return i;
        return -1;
    endfunction

    task automatic map_digram(inout logic [7:0] a, inout logic [7:0] b, input logic backward);
        int i1, i2, r1, c1, r2, c2, t, shift;
        i1 = find_cell(a);
        i2 = find_cell(b);
        if (i1 < 0 || i2 < 0)
            return;
        shift = backward ? SQUARE_SIDE - 1 : 1;
        r1 = i1 / SQUARE_SIDE;
        c1 = i1 % SQUARE_SIDE;
        r2 = i2 / SQUARE_SIDE;
        c2 = i2 % SQUARE_SIDE;
        if (r1 == r2)
        begin
            c1 = (c1 + shift) % SQUARE_SIDE;
            c2 = (c2 + shift) % SQUARE_SIDE;
        end
        else if (c1 == c2)
        begin
            r1 = (r1 + shift) % SQUARE_SIDE;
            r2 = (r2 + shift) % SQUARE_SIDE;
        end
        else
        begin
            t  = c1;
            c1 = c2;
            c2 = t;
        end
        a = key_sq[r1 * SQUARE_SIDE + c1];
        b = key_sq[r2 * SQUARE_SIDE + c2];
    endtask

    task automatic next_cipher_chars(input logic [7:0] c, input logic eom);
        logic [7:0] run [$];
        logic [7:0] a, b;
        bit         doubled;
        rsp_t       r;
        if (!pair_open)
        begin
            first_letter = c;
            pair_open    = 1'b1;
        end
        else if (cur_mode == MODE_ENCIPHER)
        begin
            doubled = (first_letter == c);
            a = first_letter;
            b = doubled ? FILLER : c;
            map_digram(a, b, 1'b0);
            run.push_back(a);
            run.push_back(b);
            // a doubled letter stays open as the next first letter
            if (doubled)
                first_letter = c;
            else
                pair_open = 1'b0;
        end
        else
        begin
            a = first_letter;
            b = c;
            pair_open = 1'b0;
            map_digram(a, b, 1'b1);
            if (held_valid)
            begin
                run.push_back(held_letter);
                if (a != held_letter)
                    run.push_back(FILLER);
                held_valid = 1'b0;
            end
            if (b == FILLER)
            begin
                held_letter = a;
                held_valid  = 1'b1;
            end
            else
            begin
                run.push_back(a);
                run.push_back(b);
            end
        end
        if (eom)
        begin
            if (held_valid)
            begin
                run.push_back(held_letter);
                run.push_back(FILLER);
            end
            held_valid = 1'b0;
            pair_open  = 1'b0;
        end
        foreach (run[i])
        begin
            r.char_out    = run[i];
            r.last_in_run = (i == run.size() - 1);
            pending_chars.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40)
            $display("%0t mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected result %02h", rsp.char_out));
            else
            begin
                next_result = pending_chars.pop_front();
                if (rsp.char_out !== next_result.char_out)
                    report_mismatch($sformatf("char_out %02h, expected %02h",
                                              rsp.char_out, next_result.char_out));
                if (rsp.last_in_run !== next_result.last_in_run)
                    report_mismatch($sformatf("last_in_run %b, expected %b on %02h",
                                              rsp.last_in_run, next_result.last_in_run,
                                              next_result.char_out));
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold when asked for
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic offer_char(input logic [7:0] c, input logic eom);
        req_t item;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        item.char_in        = c;
        item.end_of_message = eom;
        req       <= item;
        req_valid <= 1'b1;
        next_cipher_chars(c, eom);
        chars_offered++;
        // hold the request until taken
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_settings(input logic m, input key_square_t k);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= {junk[63:1], m};
        @(negedge clk);
        cfg_index <= REG_KEY_LO;
        cfg_data  <= k[7:0];
        @(negedge clk);
        cfg_index <= REG_KEY_MID;
        cfg_data  <= k[15:8];
        @(negedge clk);
        cfg_index <= REG_KEY_HI;
        cfg_data  <= k[23:16];
        @(negedge clk);
        cfg_index <= REG_KEY_LAST;
        cfg_data  <= {junk[63:8], k[24]};
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_mode  = m;
        key_sq    = k;
    endtask

    function automatic key_square_t key_from_text(input string s);
        key_square_t k;
        for (int i = 0; i < CELLS; i++)
            k[i] = s[i];
        return k;
    endfunction

    function automatic key_square_t random_key();
        key_square_t k;
        logic [7:0]  letters [26];
        logic [7:0]  t;
        int          j;
        for (int i = 0; i < 26; i++)
            letters[i] = 8'(8'h61 + i);
        for (int i = 25; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = letters[i];
            letters[i] = letters[j];
            letters[j] = t;
        end
        for (int i = 0; i < CELLS; i++)
            k[i] = letters[i];
        // sometimes spoil a few cells with repeats or stray bytes
        if ($urandom_range(0, 3) == 0)
            for (int n = 0; n < 3; n++)
                k[$urandom_range(0, CELLS - 1)] =
                    $urandom_range(0, 1) ? k[$urandom_range(0, CELLS - 1)] : 8'($urandom);
        return k;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return key_sq[$urandom_range(0, CELLS - 1)];
        if (r < 85)
            return FILLER;
        return 8'($urandom);
    endfunction

    // Offer the ciphertext of a plaintext digram under the current square
    task automatic offer_plain_pair(input logic [7:0] a, input logic [7:0] b, input logic eom);
        logic [7:0] x, y;
        x = a;
        y = b;
        map_digram(x, y, 1'b0);
        offer_char(x, 1'b0);
        offer_char(y, eom);
    endtask

    task automatic send_message(input int pairs, input bit close);
        logic [7:0] a, b, prev_a;
        bit         prev_x, odd;
        prev_x = 1'b0;
        prev_a = '0;
        odd    = ($urandom_range(0, 3) == 0);
        for (int p = 0; p < pairs; p++)
        begin
            a = pick_char();
            b = pick_char();
            if (cur_mode == MODE_DECIPHER && $urandom_range(0, 4) != 0)
            begin
                // well-formed ciphertext: split doubles so the held-letter path is hit
                if (prev_x && $urandom_range(0, 1))
                    a = prev_a;
                if ($urandom_range(0, 2) == 0)
                    b = FILLER;
                prev_x = (b == FILLER);
                prev_a = a;
                map_digram(a, b, 1'b0);
            end
            else if (cur_mode == MODE_ENCIPHER && $urandom_range(0, 3) == 0)
                b = a;
            offer_char(a, 1'b0);
            offer_char(b, close && !odd && p == pairs - 1);
        end
        if (close && odd)
            offer_char(pick_char(), 1'b1);
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            offer_char(8'($urandom), $urandom_range(0, 5) == 0);
    endtask

    task automatic test_reset_square();
        offer_char(8'h00, 1'b0);
        offer_char(8'hff, 1'b1);
        wait_until_drained();
    endtask

    task automatic test_encipher_rules();
        write_settings(MODE_ENCIPHER, key_from_text("abcdefghiklmnopqrstuvwxyz"));
        offer_char("a", 1'b0);
        offer_char("v", 1'b0);
        offer_char("a", 1'b0);
        offer_char("z", 1'b0);
        offer_char("l", 1'b0);
        offer_char("l", 1'b0);
        offer_char("o", 1'b0);
        offer_char(8'h00, 1'b0);
        offer_char(8'hff, 1'b0);
        // trailing odd letter is dropped
        offer_char("k", 1'b1);
        wait_until_drained();
    endtask

    task automatic test_decipher_rules();
        write_settings(MODE_DECIPHER, key_from_text("abcdefghiklmnopqrstuvwxyz"));
        offer_plain_pair("l", FILLER, 1'b0);
        offer_plain_pair("l", "o", 1'b0);
        offer_plain_pair("q", FILLER, 1'b0);
        // both letters in one cell take the row rule
        offer_char("a", 1'b0);
        offer_char("a", 1'b0);
        wait_until_drained();
    endtask

    task automatic test_mode_switch();
        offer_plain_pair("r", FILLER, 1'b0);
        wait_until_drained();
        // held letter survives the switch and is flushed at end of message
        write_settings(MODE_ENCIPHER, key_sq);
        offer_char("a", 1'b0);
        offer_char("c", 1'b1);
        wait_until_drained();
    endtask

    task automatic test_repeated_cells();
        write_settings(MODE_ENCIPHER, key_from_text("abcdeafghiklmnaopqrstuvwx"));
        offer_char("a", 1'b0);
        offer_char("g", 1'b1);
        wait_until_drained();
    endtask

    task automatic test_random_messages();
        key_square_t k;
        logic        m;
        int          round_start;
        idle_on = 1'b1;
        for (int round = 0; round < 8; round++)
        begin
            if (round == 0)
                k = '1;
            else if (round == 1)
                k = '0;
            else
                k = random_key();
            m = (round % 2 == 0) ? MODE_DECIPHER : MODE_ENCIPHER;
            if (round >= 4 && $urandom_range(0, 1))
                m = ~m;
            write_settings(m, k);
            round_start = chars_offered;
            while (chars_offered - round_start < 25)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise($urandom_range(1, 6));
                else
                    send_message($urandom_range(1, 6), $urandom_range(0, 5) != 0);
            end
            wait_until_drained();
        end
    endtask

    task automatic test_stalled_output();
        int first_count;
        idle_on = 1'b0;
        write_settings(MODE_ENCIPHER, random_key());
        first_count  = chars_offered;
        hold_request = LONG_HOLD;
        while (chars_offered - first_count < 40)
            send_message($urandom_range(2, 6), 1'b1);
        wait_until_drained();
    endtask

    task automatic test_steady_stream();
        int first_count;
        idle_on = 1'b0;
        for (int half = 0; half < 2; half++)
        begin
            write_settings(half == 0 ? MODE_DECIPHER : MODE_ENCIPHER, random_key());
            first_count = chars_offered;
            while (chars_offered - first_count < 50)
                send_message($urandom_range(1, 6), 1'b1);
            wait_until_drained();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_square();
        test_encipher_rules();
        test_decipher_rules();
        test_mode_switch();
        test_repeated_cells();
        test_random_messages();
        test_stalled_output();
        test_steady_stream();
        wait_until_drained();
        if (error_count == 0)
            $display("[playfair_digram_cipher] OK");
        else
            $display("[playfair_digram_cipher] ERROR");
        $finish;
    end

endmodule
